### src/cst_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and keyword/symbol tables for the C-like tokenizer.
// No dependencies; imported by every cst_* module and the top level.
package cst_pkg;

    localparam int KIND_W      = 5;
    localparam int LINE_W      = 16;
    localparam int COL_W       = 12;
    localparam int LEN_OUT_W   = 6;
    localparam int LEN_W       = 7;    // holds lengths up to 64
    localparam int N_KW        = 13;
    localparam int KW_TEXT_W   = 112;  // longest keyword is 14 bytes
    localparam int JQ_DEPTH    = 4;
    localparam int OQ_DEPTH    = 4;
    localparam int MAX_IDENT_DEF = 32;

    localparam logic [KIND_W-1:0] KIND_SYM0    = 5'd13;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd21;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd22;
    localparam logic [KIND_W-1:0] KIND_END     = 5'd23;

    typedef struct packed {
        logic              a_valid;
        logic [KIND_W-1:0] a_kind;
        logic [LINE_W-1:0] a_line;
        logic [COL_W-1:0]  a_col;
        logic [LEN_W-1:0]  a_len;
        logic              a_trunc;
        logic              b_valid;
        logic [KIND_W-1:0] b_kind;
        logic [LINE_W-1:0] b_line;
        logic [COL_W-1:0]  b_col;
    } t_job;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [LINE_W-1:0]    line;
        logic [COL_W-1:0]     col;
        logic [LEN_OUT_W-1:0] len;
        logic [7:0]           ch;
        logic                 trunc;
        logic                 last;
    } t_res;

    function automatic logic [KW_TEXT_W-1:0] kw_text(input logic [3:0] k);
        case (k)
            4'd0:    return "namespace";
            4'd1:    return "enum";
            4'd2:    return "class";
            4'd3:    return "struct";
            4'd4:    return "public";
            4'd5:    return "protected";
            4'd6:    return "private";
            4'd7:    return "virtual";
            4'd8:    return "override";
            4'd9:    return "final";
            4'd10:   return {"ENUM", "_META"};
            4'd11:   return {"CLASS", "_META"};
            4'd12:   return {"INTERFACE", "_META"};
            default: return '0;
        endcase
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        case (k)
            4'd0:    return 4'd9;
            4'd1:    return 4'd4;
            4'd2:    return 4'd5;
            4'd3:    return 4'd6;
            4'd4:    return 4'd6;
            4'd5:    return 4'd9;
            4'd6:    return 4'd7;
            4'd7:    return 4'd7;
            4'd8:    return 4'd8;
            4'd9:    return 4'd5;
            4'd10:   return 4'd9;
            4'd11:   return 4'd10;
            4'd12:   return 4'd14;
            default: return 4'd0;
        endcase
    endfunction

    // Byte of keyword k at position pos, zero past its end
    function automatic logic [7:0] kw_byte(input logic [3:0] k, input logic [LEN_W-1:0] pos);
        logic [KW_TEXT_W-1:0] s;
        logic [LEN_W-1:0]     l;
        s = kw_text(k);
        l = LEN_W'(kw_len(k));
        if (pos < l) begin
            return s[(l - 1 - pos) * 8 +: 8];
        end
        return 8'd0;
    endfunction

    // Returns {hit, kind} for the single-character symbols
    function automatic logic [KIND_W:0] sym_lookup(input logic [7:0] c);
        case (c)
            8'h7B:   return {1'b1, KIND_SYM0 + 5'd0};
            8'h7D:   return {1'b1, KIND_SYM0 + 5'd1};
            8'h3A:   return {1'b1, KIND_SYM0 + 5'd2};
            8'h3B:   return {1'b1, KIND_SYM0 + 5'd3};
            8'h3D:   return {1'b1, KIND_SYM0 + 5'd4};
            8'h2C:   return {1'b1, KIND_SYM0 + 5'd5};
            8'h3C:   return {1'b1, KIND_SYM0 + 5'd6};
            8'h3E:   return {1'b1, KIND_SYM0 + 5'd7};
            default: return {1'b0, KIND_UNKNOWN};
        endcase
    endfunction

endpackage

### src/cst_job_q.sv
`timescale 1ns / 1ps
// Small flop queue of token jobs between the scanner and the emitter.
// Depends on cst_pkg (t_job, JQ_DEPTH).
module cst_job_q (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cst_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output cst_pkg::t_job o_head,
    output logic          o_empty
);
    import cst_pkg::*;

    localparam int AW = $clog2(JQ_DEPTH);

    t_job          r_mem [JQ_DEPTH];
    logic [AW:0]   r_wr;
    logic [AW:0]   r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW-1:0] == r_rd[AW-1:0]) && (r_wr[AW] != r_rd[AW]);
    assign o_head  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr[AW-1:0]] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> !o_empty) else $error("job queue lost its contents while full");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job pushed into a full queue");
    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job popped from an empty queue");

endmodule

### src/cst_front.sv
`timescale 1ns / 1ps
// Scanner: classifies each byte, tracks line/column and comment/macro modes,
// stores identifier characters and queues token jobs. Depends on cst_pkg.
module cst_front #(
    parameter int MAX_IDENT = cst_pkg::MAX_IDENT_DEF,
    parameter int PW        = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  logic [7:0]    i_text_byte,
    input  logic          i_end_of_text,
    output logic          full,
    input  logic          i_jq_full,
    output logic          o_jq_push,
    output cst_pkg::t_job o_job,
    output logic          o_cw_en,
    output logic [PW-2:0] o_cw_addr,
    output logic [7:0]    o_cw_data,
    input  logic [PW-1:0] i_rd_ptr
);
    import cst_pkg::*;

    localparam int CNT_W      = $clog2(MAX_IDENT + 1);
    localparam int CHAR_DEPTH = 2 ** (PW - 1);

    typedef enum logic [3:0] {
        S_NORMAL, S_SLASH, S_LCMT, S_BLOCK, S_BSTAR, S_MACRO, S_MACRO_BS, S_IDENT
    } t_mode;

    t_mode             r_mode, n_mode;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_ovf, n_ovf;
    logic [N_KW-1:0]   r_match, n_match;
    logic [LINE_W-1:0] r_line, n_line, r_sline, n_sline;
    logic [COL_W-1:0]  r_col, n_col, r_scol, n_scol;
    logic [PW-1:0]     r_wr, n_wr, r_commit, n_commit;

    logic              accept;
    logic              char_full;
    logic              kw_hit;
    logic [3:0]        kw_idx;
    logic [KIND_W:0]   sym;
    logic              is_space, is_start, is_more;
    t_job              job;

    assign char_full = (r_wr - i_rd_ptr) == PW'(CHAR_DEPTH);
    assign full      = i_jq_full || char_full;
    assign accept    = push && !full;
    assign o_jq_push = accept && (job.a_valid || job.b_valid);
    assign o_job     = job;

    assign is_space = (i_text_byte == 8'h20) || (i_text_byte >= 8'h09 && i_text_byte <= 8'h0D);
    assign is_start = (i_text_byte >= 8'h61 && i_text_byte <= 8'h7A)
                   || (i_text_byte >= 8'h41 && i_text_byte <= 8'h5A) || (i_text_byte == 8'h5F);
    assign is_more  = is_start || (i_text_byte >= 8'h30 && i_text_byte <= 8'h39);
    assign sym      = sym_lookup(i_text_byte);

    // First keyword whose prefix match survived and whose length equals r_cnt
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int k = N_KW - 1; k >= 0; k--) begin
            if (r_match[k] && !r_ovf && (LEN_W'(r_cnt) == LEN_W'(kw_len(4'(k))))) begin
                kw_hit = 1'b1;
                kw_idx = 4'(k);
            end
        end
    end

    always_comb begin
        logic flush, slash_unk, do_lex, append;
        logic [PW-1:0] base_wr;
        flush     = 1'b0;
        slash_unk = 1'b0;
        do_lex    = 1'b0;
        append    = 1'b0;
        n_mode    = r_mode;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_match   = r_match;
        n_line    = r_line;
        n_col     = r_col;
        n_sline   = r_sline;
        n_scol    = r_scol;
        job       = '0;
        o_cw_en   = 1'b0;
        o_cw_data = i_text_byte;

        if (i_end_of_text) begin
            flush     = (r_mode == S_IDENT);
            slash_unk = (r_mode == S_SLASH);
        end else begin
            case (r_mode)
                S_SLASH: begin
                    if (i_text_byte == "/") begin
                        n_mode = S_LCMT;
                    end else if (i_text_byte == "*") begin
                        n_mode = S_BLOCK;
                    end else begin
                        slash_unk = 1'b1;
                        do_lex    = 1'b1;
                    end
                end
                S_LCMT: begin
                    if (i_text_byte == 8'h0A) n_mode = S_NORMAL;
                end
                S_BLOCK: begin
                    if (i_text_byte == "*") n_mode = S_BSTAR;
                end
                S_BSTAR: begin
                    if (i_text_byte == "/") n_mode = S_NORMAL;
                    else if (i_text_byte != "*") n_mode = S_BLOCK;
                end
                S_MACRO: begin
                    if (i_text_byte == 8'h0A) n_mode = S_NORMAL;
                    else if (i_text_byte == 8'h5C) n_mode = S_MACRO_BS;
                end
                S_MACRO_BS: begin
                    if (i_text_byte != 8'h5C) n_mode = S_MACRO;
                end
                S_IDENT: begin
                    if (is_more) begin
                        if (r_cnt < CNT_W'(MAX_IDENT)) begin
                            append = 1'b1;
                            n_cnt  = r_cnt + 1'b1;
                            for (int k = 0; k < N_KW; k++) begin
                                n_match[k] = r_match[k]
                                    && (i_text_byte == kw_byte(4'(k), LEN_W'(r_cnt)));
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        flush  = 1'b1;
                        do_lex = 1'b1;
                    end
                end
                default: do_lex = 1'b1;
            endcase
        end

        // keyword flush drops its stored characters, identifier flush keeps them
        base_wr  = (flush && kw_hit) ? r_commit : r_wr;
        n_commit = (flush && !kw_hit) ? r_wr : r_commit;
        n_wr     = base_wr;
        o_cw_addr = base_wr[PW-2:0];
        if (append) begin
            o_cw_en = accept;
            n_wr    = base_wr + 1'b1;
        end

        if (flush) begin
            job.a_valid = 1'b1;
            job.a_line  = r_sline;
            job.a_col   = r_scol;
            if (kw_hit) begin
                job.a_kind = KIND_W'(kw_idx);
            end else begin
                job.a_kind  = KIND_IDENT;
                job.a_len   = LEN_W'(r_cnt);
                job.a_trunc = r_ovf;
            end
        end else if (slash_unk) begin
            job.a_valid = 1'b1;
            job.a_kind  = KIND_UNKNOWN;
            job.a_line  = r_sline;
            job.a_col   = r_scol;
        end

        if (do_lex) begin
            n_mode = S_NORMAL;
            if (is_space) begin
                n_mode = S_NORMAL;
            end else if (i_text_byte == "/") begin
                n_sline = r_line;
                n_scol  = r_col;
                n_mode  = S_SLASH;
            end else if (i_text_byte == "#") begin
                n_mode = S_MACRO;
            end else if (is_start) begin
                n_sline = r_line;
                n_scol  = r_col;
                n_cnt   = CNT_W'(1);
                n_ovf   = 1'b0;
                for (int k = 0; k < N_KW; k++) begin
                    n_match[k] = (i_text_byte == kw_byte(4'(k), '0));
                end
                n_mode  = S_IDENT;
                o_cw_en = accept;
                n_wr    = base_wr + 1'b1;
            end else begin
                job.b_valid = 1'b1;
                job.b_kind  = sym[KIND_W-1:0];
                job.b_line  = r_line;
                job.b_col   = r_col;
            end
        end

        if (i_end_of_text) begin
            job.b_valid = 1'b1;
            job.b_kind  = KIND_END;
            job.b_line  = r_line;
            job.b_col   = r_col;
            n_mode  = S_NORMAL;
            n_cnt   = '0;
            n_ovf   = 1'b0;
            n_line  = '0;
            n_col   = '0;
            n_sline = '0;
            n_scol  = '0;
        end else if (i_text_byte == 8'h0A) begin
            if (r_line != '1) n_line = r_line + 1'b1;
            n_col = '0;
        end else if (r_col != '1) begin
            n_col = r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= S_NORMAL;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_match  <= '0;
            r_line   <= '0;
            r_col    <= '0;
            r_sline  <= '0;
            r_scol   <= '0;
            r_wr     <= '0;
            r_commit <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_match  <= n_match;
            r_line   <= n_line;
            r_col    <= n_col;
            r_sline  <= n_sline;
            r_scol   <= n_scol;
            r_wr     <= n_wr;
            r_commit <= n_commit;
        end
    end

    a_ident_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == S_IDENT) |-> (r_cnt != '0)) else $error("identifier mode with no characters");
    a_char_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - i_rd_ptr) <= PW'(CHAR_DEPTH)) else $error("character store overrun");
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_text) |=> (r_mode == S_NORMAL) && (r_line == '0) && (r_col == '0))
        else $error("end of text did not restart the scanner");

endmodule

### src/cst_back.sv
`timescale 1ns / 1ps
// Emitter: expands token jobs into result items, reading identifier
// characters from the character store, into a small output queue. Uses cst_pkg.
module cst_back #(
    parameter int PW = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cst_pkg::t_job                  i_jq_head,
    input  logic                           i_jq_empty,
    output logic                           o_jq_pop,
    input  logic                           i_cw_en,
    input  logic [PW-2:0]                  i_cw_addr,
    input  logic [7:0]                     i_cw_data,
    output logic [PW-1:0]                  o_rd_ptr,
    output logic                           empty,
    input  logic                           pop,
    output logic [cst_pkg::KIND_W-1:0]     o_token_kind,
    output logic [cst_pkg::LINE_W-1:0]     o_token_line,
    output logic [cst_pkg::COL_W-1:0]      o_token_column,
    output logic [cst_pkg::LEN_OUT_W-1:0]  o_ident_length,
    output logic [7:0]                     o_ident_char,
    output logic                           o_ident_truncated,
    output logic                           o_last_of_run
);
    import cst_pkg::*;

    localparam int CHAR_DEPTH = 2 ** (PW - 1);
    localparam int OAW = $clog2(OQ_DEPTH);

    logic [7:0]     r_cmem [CHAR_DEPTH];
    logic [7:0]     r_rd_data;
    logic [PW-1:0]  r_rd_ptr;
    logic [LEN_W-1:0] r_k;
    logic           r_phase_b;

    logic           r_s1_valid;
    logic           r_s1_is_id;
    t_res           r_s1;

    t_res           r_oq [OQ_DEPTH];
    logic [OAW:0]   r_oq_cnt;
    logic [OAW-1:0] r_oq_wr, r_oq_rd;

    logic           credit, issue, use_a, is_id, a_done, oq_pop;
    t_res           res;
    t_res           s1_out;

    assign o_rd_ptr = r_rd_ptr;
    assign credit   = ({1'b0, r_oq_cnt} + (OAW + 2)'(r_s1_valid)) < (OAW + 2)'(OQ_DEPTH);
    assign issue    = !i_jq_empty && credit;
    assign use_a    = i_jq_head.a_valid && !r_phase_b;
    assign is_id    = use_a && (i_jq_head.a_kind == KIND_IDENT);
    assign a_done   = !is_id || (r_k == i_jq_head.a_len - 1'b1);
    assign o_jq_pop = issue && (!use_a || (a_done && !i_jq_head.b_valid));

    always_comb begin
        res = '0;
        if (use_a) begin
            res.kind  = i_jq_head.a_kind;
            res.line  = i_jq_head.a_line;
            res.col   = i_jq_head.a_col;
            res.len   = i_jq_head.a_len[LEN_OUT_W-1:0];
            res.trunc = i_jq_head.a_trunc;
            res.last  = a_done && !i_jq_head.b_valid;
        end else begin
            res.kind  = i_jq_head.b_kind;
            res.line  = i_jq_head.b_line;
            res.col   = i_jq_head.b_col;
            res.last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cw_en) begin
            r_cmem[i_cw_addr] <= i_cw_data;
        end
        r_rd_data <= r_cmem[r_rd_ptr[PW-2:0]];
        r_s1      <= res;
        r_s1_is_id <= is_id;
    end

    assign oq_pop = pop && !empty;
    assign empty  = (r_oq_cnt == '0);

    always_comb begin
        s1_out    = r_s1;
        s1_out.ch = r_s1_is_id ? r_rd_data : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_oq[r_oq_wr] <= s1_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr   <= '0;
            r_k        <= '0;
            r_phase_b  <= 1'b0;
            r_s1_valid <= 1'b0;
            r_oq_cnt   <= '0;
            r_oq_wr    <= '0;
            r_oq_rd    <= '0;
        end else begin
            r_s1_valid <= issue;
            if (issue) begin
                if (is_id) begin
                    r_rd_ptr <= r_rd_ptr + 1'b1;
                end
                if (use_a && a_done) begin
                    r_k       <= '0;
                    r_phase_b <= i_jq_head.b_valid;
                end else if (is_id) begin
                    r_k       <= r_k + 1'b1;
                end
                if (!use_a) begin
                    r_phase_b <= 1'b0;
                end
            end
            if (r_s1_valid) r_oq_wr <= r_oq_wr + 1'b1;
            if (oq_pop)     r_oq_rd <= r_oq_rd + 1'b1;
            r_oq_cnt <= r_oq_cnt + (OAW + 1)'(r_s1_valid) - (OAW + 1)'(oq_pop);
        end
    end

    assign o_token_kind      = r_oq[r_oq_rd].kind;
    assign o_token_line      = r_oq[r_oq_rd].line;
    assign o_token_column    = r_oq[r_oq_rd].col;
    assign o_ident_length    = r_oq[r_oq_rd].len;
    assign o_ident_char      = r_oq[r_oq_rd].ch;
    assign o_ident_truncated = r_oq[r_oq_rd].trunc;
    assign o_last_of_run     = r_oq[r_oq_rd].last;

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_oq_cnt} + (OAW + 2)'(r_s1_valid)) <= (OAW + 2)'(OQ_DEPTH))
        else $error("output queue credit exceeded");
    a_phase_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase_b |-> (!i_jq_empty && i_jq_head.b_valid))
        else $error("second token phase without a second token");
    a_k_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != '0) |-> (!i_jq_empty && is_id))
        else $error("identifier character index left mid-run");

endmodule

### src/cpp_subset_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the C-like tokenizer: scanner, job queue and emitter.
// Depends on cst_pkg, cst_front, cst_job_q, cst_back.
// Takes one byte (or an end-of-text mark) per cycle whenever full is low and
// produces token items on a queue-style output. Each token yields one output
// item, and an identifier yields one per stored character, drawn from a
// character store of 2*2^ceil(log2(MAX_IDENT)) bytes at one read per cycle
// while the output queue has room. full rises when the four-entry job queue or
// the character store is full, so long identifier bursts are absorbed while
// the scanner keeps taking text; a registered stage feeds the output queue.
module cpp_subset_tokenizer #(
    parameter int MAX_IDENT = cst_pkg::MAX_IDENT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_text_byte,
    input  logic                           i_end_of_text,
    output logic                           empty,
    input  logic                           pop,
    output logic [cst_pkg::KIND_W-1:0]     o_token_kind,
    output logic [cst_pkg::LINE_W-1:0]     o_token_line,
    output logic [cst_pkg::COL_W-1:0]      o_token_column,
    output logic [cst_pkg::LEN_OUT_W-1:0]  o_ident_length,
    output logic [7:0]                     o_ident_char,
    output logic                           o_ident_truncated,
    output logic                           o_last_of_run
);
    import cst_pkg::*;

    localparam int PW = $clog2(MAX_IDENT) + 2;

    t_job          jq_in, jq_head;
    logic          jq_push, jq_pop, jq_full, jq_empty;
    logic          cw_en;
    logic [PW-2:0] cw_addr;
    logic [7:0]    cw_data;
    logic [PW-1:0] rd_ptr;

    cst_front #(.MAX_IDENT(MAX_IDENT), .PW(PW)) u_front (
        .i_clk, .i_rst_n, .push, .i_text_byte, .i_end_of_text, .full,
        .i_jq_full(jq_full), .o_jq_push(jq_push), .o_job(jq_in),
        .o_cw_en(cw_en), .o_cw_addr(cw_addr), .o_cw_data(cw_data), .i_rd_ptr(rd_ptr)
    );

    cst_job_q u_jq (
        .i_clk, .i_rst_n, .i_push(jq_push), .i_job(jq_in), .o_full(jq_full),
        .i_pop(jq_pop), .o_head(jq_head), .o_empty(jq_empty)
    );

    cst_back #(.PW(PW)) u_back (
        .i_clk, .i_rst_n, .i_jq_head(jq_head), .i_jq_empty(jq_empty), .o_jq_pop(jq_pop),
        .i_cw_en(cw_en), .i_cw_addr(cw_addr), .i_cw_data(cw_data), .o_rd_ptr(rd_ptr),
        .empty, .pop, .o_token_kind, .o_token_line, .o_token_column, .o_ident_length,
        .o_ident_char, .o_ident_truncated, .o_last_of_run
    );

endmodule
